// File: design/sv39ptw_pkg.sv
// Shared widths, entry bit positions and register indexes of the Sv39 page table walker.
package sv39ptw_pkg;

    localparam int unsigned VA_W      = 64;
    localparam int unsigned PA_W      = 64;
    localparam int unsigned PTE_W     = 64;
    localparam int unsigned PPN_W     = 44;
    localparam int unsigned VPN_W     = 9;
    localparam int unsigned WIDX_W    = 12;
    localparam int unsigned PERM_W    = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 44;

    // Action codes of an input transaction.
    localparam logic ACT_WRITE     = 1'b0;
    localparam logic ACT_TRANSLATE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATE_ON = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PAGE    = 1'b1;

    // Walk level codes.
    localparam logic [1:0] LVL_GIGA = 2'd2;
    localparam logic [1:0] LVL_MEGA = 2'd1;
    localparam logic [1:0] LVL_PAGE = 2'd0;

    // Entry bit positions.
    localparam int unsigned PTE_V_BIT    = 0;
    localparam int unsigned PTE_PERM_LO  = 1;
    localparam int unsigned PTE_PPN_LO   = 10;

    // Permissions reported when translation is off: read, write and execute.
    localparam logic [PERM_W-1:0] PERM_IDENTITY = 4'b0111;

    typedef logic [PTE_W-1:0] t_pte;
    typedef logic [PPN_W-1:0] t_ppn;
    typedef logic [VPN_W-1:0] t_vpn;

endpackage

// File: design/sv39_page_table_walk.sv
// Sv39 three-level page table walker with its own page table memory.
//
// The block holds TABLE_WORDS 64-bit page table entries in one synchronous RAM with a
// single read port and a single write port. Each input transaction either writes one
// table word (action 0) or translates a virtual address (action 1); every transaction
// produces exactly one result transaction. With translation on, the walk starts in the
// root table at root_page and uses VA[38:30], VA[29:21] and VA[20:12] as level indexes,
// stopping at the first valid entry with any of R, W or X set or at the last level, so
// 1 GiB, 2 MiB and 4 KiB leaves are all returned; an invalid entry at any level is a
// miss. The table word address is the low bits of {page number, index}, so TABLE_WORDS
// must be a power of two. After reset the block runs a clearing pass that zeroes every
// RAM word, during which input stays stalled (configuration writes are taken at any
// time). An input item is accepted only in the idle state, so the next item waits
// until the previous result has been loaded into the output register. A translation
// reads one table level at a time, because each level's address depends on the
// previous entry read from the RAM, whose read data is registered. The output register
// lets a new input transaction be accepted while the previous result still waits to be
// taken.
module sv39_page_table_walk #(
    parameter int unsigned TABLE_WORDS = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port.
    input  logic                                   i_cfg_we,
    input  logic [sv39ptw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sv39ptw_pkg::CFG_DAT_W-1:0]      i_cfg_wdata,
    // Input channel.
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_action,
    input  logic [sv39ptw_pkg::WIDX_W-1:0]         i_word_index,
    input  logic [sv39ptw_pkg::PTE_W-1:0]          i_word_data,
    input  logic [sv39ptw_pkg::VA_W-1:0]           i_virt_addr,
    // Output channel.
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_mapped,
    output logic [sv39ptw_pkg::PA_W-1:0]           o_phys_addr,
    output logic [sv39ptw_pkg::PERM_W-1:0]         o_permissions
);
    import sv39ptw_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_WORDS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_WORDS - 1);

    // Table word address of index idx in the table at page ppn, modulo the depth.
    function automatic logic [AW-1:0] tbl_addr(input t_ppn ppn, input t_vpn idx);
        logic [PPN_W+VPN_W-1:0] full;
        full = {ppn, idx};
        return full[AW-1:0];
    endfunction

    // Control state.
    logic [1:0]      r_state, n_state;
    logic [AW-1:0]   r_clr_addr;
    logic [1:0]      r_lvl, n_lvl;
    logic            r_out_valid;
    logic            r_translate_on;
    t_ppn            r_root_page;

    // Payload state.
    logic [VA_W-1:0] r_va;
    logic            r_res_mapped, n_res_mapped;
    logic [PA_W-1:0] r_res_pa, n_res_pa;
    logic [PERM_W-1:0] r_res_perm, n_res_perm;
    logic            r_mapped;
    logic [PA_W-1:0] r_phys_addr;
    logic [PERM_W-1:0] r_perm;

    // Table memory and its ports.
    t_pte            r_mem [TABLE_WORDS];
    t_pte            r_rd_data;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_pte            mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;

    logic            in_accept;
    logic            out_load;
    logic            ent_valid;
    logic            ent_leaf;
    t_ppn            ent_ppn;
    t_vpn            next_vpn;
    logic [29:0]     page_off;
    logic [AW+WIDX_W-1:0] widx_ext;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == ST_RESP) && (!r_out_valid || !i_out_stall);

    assign o_out_valid   = r_out_valid;
    assign o_mapped      = r_mapped;
    assign o_phys_addr   = r_phys_addr;
    assign o_permissions = r_perm;

    // Fields of the entry that came back from the RAM.
    assign ent_valid = r_rd_data[PTE_V_BIT];
    assign ent_leaf  = (r_rd_data[PTE_PERM_LO+2:PTE_PERM_LO] != 3'b000) || (r_lvl == LVL_PAGE);
    assign ent_ppn   = r_rd_data[PTE_PPN_LO+PPN_W-1:PTE_PPN_LO];
    assign widx_ext  = {{AW{1'b0}}, i_word_index};

    // Index of the level below the current one, and the in-page offset of a leaf here.
    always_comb begin
        next_vpn = r_va[20:12];
        page_off = 30'(r_va[11:0]);
        case (r_lvl)
            LVL_GIGA: begin
                next_vpn = r_va[29:21];
                page_off = r_va[29:0];
            end
            LVL_MEGA: begin
                next_vpn = r_va[20:12];
                page_off = 30'(r_va[20:0]);
            end
            default: begin
                next_vpn = r_va[20:12];
                page_off = 30'(r_va[11:0]);
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_lvl        = r_lvl;
        n_res_mapped = r_res_mapped;
        n_res_pa     = r_res_pa;
        n_res_perm   = r_res_perm;
        mem_we       = 1'b0;
        mem_waddr    = r_clr_addr;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = tbl_addr(r_root_page, i_virt_addr[38:30]);
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_res_mapped = 1'b0;
                    n_res_pa     = '0;
                    n_res_perm   = '0;
                    n_state      = ST_RESP;
                    if (i_action == ACT_WRITE) begin
                        mem_we    = 1'b1;
                        mem_waddr = widx_ext[AW-1:0];
                        mem_wdata = i_word_data;
                    end else if (!r_translate_on) begin
                        n_res_mapped = 1'b1;
                        n_res_pa     = i_virt_addr;
                        n_res_perm   = PERM_IDENTITY;
                    end else begin
                        mem_re  = 1'b1;
                        n_lvl   = LVL_GIGA;
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (!ent_valid) begin
                    n_state = ST_RESP;
                end else if (ent_leaf) begin
                    n_res_mapped = 1'b1;
                    n_res_pa     = {8'b0, ent_ppn, 12'b0} + {34'b0, page_off};
                    n_res_perm   = r_rd_data[PTE_PERM_LO+PERM_W-1:PTE_PERM_LO];
                    n_state      = ST_RESP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = tbl_addr(ent_ppn, next_vpn);
                    n_lvl     = r_lvl - 2'd1;
                end
            end
            ST_RESP: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Table RAM: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr_addr     <= '0;
            r_lvl          <= LVL_GIGA;
            r_out_valid    <= 1'b0;
            r_translate_on <= 1'b0;
            r_root_page    <= '0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TRANSLATE_ON: r_translate_on <= i_cfg_wdata[0];
                    CFG_ROOT_PAGE:    r_root_page    <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_va <= i_virt_addr;
        end
        r_res_mapped <= n_res_mapped;
        r_res_pa     <= n_res_pa;
        r_res_perm   <= n_res_perm;
        if (out_load) begin
            r_mapped    <= r_res_mapped;
            r_phys_addr <= r_res_pa;
            r_perm      <= r_res_perm;
        end
    end

    // An accepted transaction always takes the walker out of the idle state in the next cycle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != ST_IDLE))
        else $error("input accepted but walker stayed idle");

    // No result is presented while the table is still being cleared.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_out_valid)
        else $error("result valid during clearing pass");

    // The last level always ends the walk.
    a_walk_ends_at_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && r_lvl == LVL_PAGE) |=> (r_state == ST_RESP))
        else $error("walk continued past the last level");

    // A new result only appears after the response state.
    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_RESP))
        else $error("result loaded outside the response state");

    // The walk never issues a read while a leaf or a miss is being reported.
    a_read_only_when_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_re && r_state == ST_WALK) |-> (ent_valid && !ent_leaf))
        else $error("table read issued after the walk ended");

endmodule
